>>> hdl/pid_controller_clamp_antiwindup_assert.svh
// assertion macros for the pid controller block
`ifndef PID_CONTROLLER_CLAMP_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_CLAMP_ANTIWINDUP_ASSERT_SVH

`ifndef SYNTH
// combinational implication checked at every clock edge
`define PIDCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid controller check failed");
// implication whose consequent is checked in the next cycle
`define PIDCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid controller check failed");
`else
`define PIDCA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIDCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/pidca_pkg.sv
package pidca_pkg;

  localparam int FracBits    = 12;
  localparam int SampleWidth = 16;
  localparam int GainWidth   = 16;
  localparam int IntegWidth  = 48;
  localparam int ErrWidth    = SampleWidth + 1;
  localparam int DiffWidth   = ErrWidth + 1;
  localparam int MulBWidth   = GainWidth + ErrWidth;       // holds p
  localparam int ProdWidth   = GainWidth + MulBWidth;      // holds ki*p
  localparam int CandWidth   = IntegWidth + 1;
  localparam int SumWidth    = IntegWidth + 2;
  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_OUT_MAX = 3'd3,
    CFG_OUT_MIN = 3'd4,
    CFG_DER_EN  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_ADD_I,
    ST_SUM,
    ST_FIN
  } state_e;

endpackage

>>> hdl/pidca_if.sv
interface pidca_req_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      kind;
  logic signed [pidca_pkg::SampleWidth-1:0]  reference;
  logic signed [pidca_pkg::SampleWidth-1:0]  feedback;

  modport source (output valid, kind, reference, feedback, input ready);
  modport sink   (input valid, kind, reference, feedback, output ready);
endinterface

interface pidca_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pidca_pkg::SampleWidth-1:0]  drive;
  logic                                      saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

interface pidca_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [pidca_pkg::CfgIdxWidth-1:0]         index;
  logic [pidca_pkg::GainWidth-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pidca_mul.sv
module pidca_mul (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [pidca_pkg::GainWidth-1:0]  a_i,
  input  logic signed [pidca_pkg::MulBWidth-1:0]  b_i,
  output logic signed [pidca_pkg::ProdWidth-1:0]  prod_o
);

  logic signed [pidca_pkg::ProdWidth-1:0] prod_d;
  logic signed [pidca_pkg::ProdWidth-1:0] prod_q;

  // product always fits, so the extended multiply is exact
  assign prod_d = pidca_pkg::ProdWidth'(a_i) * pidca_pkg::ProdWidth'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> hdl/pid_controller_clamp_antiwindup.sv
// channel  role    fields                              transfer when
// req_i    sink    kind, reference, feedback           valid & ready
// rsp_o    source  drive, saturated                    valid & ready
// cfg_i    sink    index, data                         valid & ready (ready tied high)
//
// a control step runs from transfer to the next possible transfer as
// three passes through the one shared signed multiplier, one sum, one clamp
// a clear goes from idle straight to the clamp state; the result register frees the input while it waits
// rst_ni is asynchronous active low; gains and limits return to their defaults
// a stalled rsp_o holds the block in the clamp state until the result drains

`include "pid_controller_clamp_antiwindup_assert.svh"

module pid_controller_clamp_antiwindup (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidca_req_if.sink   req_i,
  pidca_rsp_if.source rsp_o,
  pidca_cfg_if.sink   cfg_i
);

  // configuration registers
  logic signed [pidca_pkg::GainWidth-1:0]   kp_q, ki_q, kd_q;
  logic signed [pidca_pkg::SampleWidth-1:0] out_max_q, out_min_q;
  logic                                     der_en_q;

  // sequencer and datapath
  pidca_pkg::state_e                        state_q, state_d;
  logic                                     kind_q;
  logic signed [pidca_pkg::ErrWidth-1:0]    err_q;
  logic signed [pidca_pkg::MulBWidth-1:0]   p_q;
  logic signed [pidca_pkg::IntegWidth-1:0]  cand_q, cand_d;
  logic signed [pidca_pkg::SumWidth-1:0]    sum_q, sum_d;

  // controller state
  logic signed [pidca_pkg::IntegWidth-1:0]  integ_q;
  logic signed [pidca_pkg::ErrWidth-1:0]    prev_q;

  // result register
  logic                                     out_valid_q, out_valid_d;
  logic signed [pidca_pkg::SampleWidth-1:0] drive_q;
  logic                                     sat_q;

  // shared multiplier
  logic                                     mul_en;
  logic signed [pidca_pkg::GainWidth-1:0]   mul_a;
  logic signed [pidca_pkg::MulBWidth-1:0]   mul_b;
  logic signed [pidca_pkg::ProdWidth-1:0]   prod;

  logic                                     req_xfer, rsp_xfer, fin_go;
  logic signed [pidca_pkg::DiffWidth-1:0]   diff;
  logic signed [pidca_pkg::ProdWidth-1:0]   ki_shift;
  logic signed [pidca_pkg::CandWidth-1:0]   cand_full;
  logic signed [pidca_pkg::SumWidth-1:0]    hi_lim, lo_lim, drive_full;
  logic                                     above, below;

  assign req_xfer    = req_i.valid & req_i.ready;
  assign rsp_xfer    = rsp_o.valid & rsp_o.ready;
  assign req_i.ready = (state_q == pidca_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // configuration writes, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= 16'sd4096;
      ki_q      <= '0;
      kd_q      <= '0;
      out_max_q <= 16'sh7fff;
      out_min_q <= 16'sh8000;
      der_en_q  <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pidca_pkg::CFG_KP:      kp_q      <= cfg_i.data;
        pidca_pkg::CFG_KI:      ki_q      <= cfg_i.data;
        pidca_pkg::CFG_KD:      kd_q      <= cfg_i.data;
        pidca_pkg::CFG_OUT_MAX: out_max_q <= cfg_i.data;
        pidca_pkg::CFG_OUT_MIN: out_min_q <= cfg_i.data;
        pidca_pkg::CFG_DER_EN:  der_en_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // error change feeds the derivative multiply
  assign diff = pidca_pkg::DiffWidth'(err_q) - pidca_pkg::DiffWidth'(prev_q);

  // multiplier schedule: kp*err, then ki*p, then kd*diff
  always_comb begin
    mul_en = 1'b0;
    mul_a  = kp_q;
    mul_b  = pidca_pkg::MulBWidth'(err_q);
    case (state_q)
      pidca_pkg::ST_MUL_P: begin
        mul_en = 1'b1;
      end
      pidca_pkg::ST_MUL_I: begin
        mul_en = 1'b1;
        mul_a  = ki_q;
        mul_b  = prod[pidca_pkg::MulBWidth-1:0];
      end
      pidca_pkg::ST_ADD_I: begin
        mul_en = 1'b1;
        mul_a  = kd_q;
        mul_b  = pidca_pkg::MulBWidth'(diff);
      end
      default: ;
    endcase
  end

  pidca_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // integrator candidate, floor of ki*p, saturated to the integrator range
  assign ki_shift  = prod >>> pidca_pkg::FracBits;
  assign cand_full = pidca_pkg::CandWidth'(integ_q) + pidca_pkg::CandWidth'(ki_shift);

  always_comb begin
    if (cand_full[pidca_pkg::CandWidth-1] != cand_full[pidca_pkg::CandWidth-2]) begin
      // overflow: pick the bound on the side of the true sign
      cand_d = {cand_full[pidca_pkg::CandWidth-1],
                {(pidca_pkg::IntegWidth-1){~cand_full[pidca_pkg::CandWidth-1]}}};
    end else begin
      cand_d = cand_full[pidca_pkg::IntegWidth-1:0];
    end
  end

  // full sum, derivative product only in pid mode
  assign sum_d = pidca_pkg::SumWidth'(p_q) + pidca_pkg::SumWidth'(cand_q)
               + (der_en_q ? pidca_pkg::SumWidth'(prod) : '0);

  // clamp limits scaled to the sum format, max checked first
  assign hi_lim     = pidca_pkg::SumWidth'(out_max_q) <<< pidca_pkg::FracBits;
  assign lo_lim     = pidca_pkg::SumWidth'(out_min_q) <<< pidca_pkg::FracBits;
  assign above      = (sum_q > hi_lim);
  assign below      = (sum_q < lo_lim);
  assign drive_full = sum_q >>> pidca_pkg::FracBits;

  // clamp state waits while the result register is full and rsp_o is not ready
  assign fin_go = (state_q == pidca_pkg::ST_FIN) & (~out_valid_q | rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (rsp_xfer) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      pidca_pkg::ST_IDLE: begin
        if (req_xfer) begin
          state_d = req_i.kind ? pidca_pkg::ST_FIN : pidca_pkg::ST_MUL_P;
        end
      end
      pidca_pkg::ST_MUL_P: state_d = pidca_pkg::ST_MUL_I;
      pidca_pkg::ST_MUL_I: state_d = pidca_pkg::ST_ADD_I;
      pidca_pkg::ST_ADD_I: state_d = pidca_pkg::ST_SUM;
      pidca_pkg::ST_SUM:   state_d = pidca_pkg::ST_FIN;
      pidca_pkg::ST_FIN: begin
        if (fin_go) begin
          state_d     = pidca_pkg::ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = pidca_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidca_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fin_go) begin
        if (kind_q) begin
          integ_q <= '0;
          prev_q  <= '0;
        end else begin
          // commit integrator only when the output is not clamped
          if (!above && !below) begin
            integ_q <= cand_q;
          end
          if (der_en_q) begin
            prev_q <= err_q;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      kind_q <= req_i.kind;
      err_q  <= pidca_pkg::ErrWidth'(req_i.reference) - pidca_pkg::ErrWidth'(req_i.feedback);
    end
    if (state_q == pidca_pkg::ST_MUL_I) begin
      p_q <= prod[pidca_pkg::MulBWidth-1:0];
    end
    if (state_q == pidca_pkg::ST_ADD_I) begin
      cand_q <= cand_d;
    end
    if (state_q == pidca_pkg::ST_SUM) begin
      sum_q <= sum_d;
    end
    if (fin_go) begin
      if (kind_q) begin
        drive_q <= '0;
        sat_q   <= 1'b0;
      end else if (above) begin
        drive_q <= out_max_q;
        sat_q   <= 1'b1;
      end else if (below) begin
        drive_q <= out_min_q;
        sat_q   <= 1'b1;
      end else begin
        drive_q <= drive_full[pidca_pkg::SampleWidth-1:0];
        sat_q   <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.drive     = drive_q;
  assign rsp_o.saturated = sat_q;

  // an accepted item always leaves the idle state
  `PIDCA_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, req_xfer,
                     state_q != pidca_pkg::ST_IDLE)
  // a new result only appears out of the clamp state
  `PIDCA_ASSERT_IMP(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q),
                    $past(state_q) == pidca_pkg::ST_FIN)
  // a saturated result carries one of the limits
  `PIDCA_ASSERT_IMP(a_sat_drive_is_limit, clk_i, rst_ni, rsp_o.valid && rsp_o.saturated,
                    rsp_o.drive == out_max_q || rsp_o.drive == out_min_q)

endmodule
